// ===== hdl/pgc_pkg.sv =====
// Shared definitions for the pretrigger gated capture block.
// Holds the result record codes; no dependencies.
package pgc_pkg;

  typedef logic rec_kind_t;

  localparam rec_kind_t KIND_DATA = 1'b0;
  localparam rec_kind_t KIND_END  = 1'b1;

  localparam int unsigned OUT_SAMPLE_W = 16;
  localparam int unsigned FRAME_W      = 32;
  localparam int unsigned COUNT_W      = 6;

endpackage

// ===== hdl/pretrigger_gated_capture_core.sv =====
// Pretrigger gated capture: top level with control sequencer and output register.
// Depends on pgc_pkg and a row of pgc_cell instances.
// Sequence: an item is taken in the idle state and decided in the next cycle; a closed
// gate or a running entry then returns to idle, while an opening gate drains the store
// as the cell chain always shifts through its full length to bring the oldest kept sample
// to the head. No new item is taken until the last one is done; output stalls hold it up.
// Reset (rst_n, synchronous, active low) closes the gate, empties the store and clears the threshold.
module pretrigger_gated_capture_core
  import pgc_pkg::*;
#(
  parameter int unsigned PRETRIGGER_DEPTH = 32,
  parameter int unsigned SAMPLE_WIDTH     = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,

  input  logic                      cfg_wr_en,
  input  logic signed [15:0]        cfg_wr_data,

  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [15:0]        in_data_sample,
  input  logic signed [15:0]        in_trigger_sample,
  input  logic [FRAME_W-1:0]        in_frame_time,

  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_record_kind,
  output logic signed [OUT_SAMPLE_W-1:0] out_sample_out,
  output logic                      out_entry_start,
  output logic [FRAME_W-1:0]        out_event_frame,
  output logic [COUNT_W-1:0]        out_pretrigger_count,
  output logic                      out_run_last
);

  localparam int unsigned CW = $clog2(PRETRIGGER_DEPTH + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WORK  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]              state_r, state_nxt;
  logic signed [15:0]      thr_r;
  logic                    gate_open_r, gate_open_nxt;
  logic [CW-1:0]           fill_r, fill_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic [SAMPLE_WIDTH-1:0] smp_r, smp_nxt;
  logic                    gate_r, gate_nxt;
  logic [FRAME_W-1:0]      frame_r, frame_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic                    kind_r, kind_nxt;
  logic [OUT_SAMPLE_W-1:0] osmp_r, osmp_nxt;
  logic                    start_r, start_nxt;
  logic [FRAME_W-1:0]      oframe_r, oframe_nxt;
  logic [COUNT_W-1:0]      ocnt_r, ocnt_nxt;
  logic                    last_r, last_nxt;

  logic                    shift_en;
  logic [SAMPLE_WIDTH-1:0] head_q;
  logic [SAMPLE_WIDTH-1:0] cell_q [PRETRIGGER_DEPTH];
  logic                    out_free;
  logic [CW:0]             pos_sum;
  logic                    skip;
  logic                    first;
  logic                    cnt_done;

  // Samples enter at the top cell and move toward cell 0, so cell 0 holds
  // the oldest sample of a full chain.
  for (genvar i = 0; i < PRETRIGGER_DEPTH; i++) begin : g_cell
    logic [SAMPLE_WIDTH-1:0] d;
    if (i == PRETRIGGER_DEPTH - 1) begin : g_top
      assign d = smp_r;
    end else begin : g_mid
      assign d = cell_q[i+1];
    end
    pgc_cell #(.W(SAMPLE_WIDTH)) u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .d_in     (d),
      .q        (cell_q[i])
    );
  end

  assign head_q   = cell_q[0];
  assign out_free = !out_valid_r || out_ready;
  assign pos_sum  = {1'b0, cnt_r} + {1'b0, fill_r};
  // Positions below the oldest kept sample hold stale data and are shifted past.
  assign skip     = pos_sum < (CW+1)'(PRETRIGGER_DEPTH);
  assign first    = pos_sum == (CW+1)'(PRETRIGGER_DEPTH);
  assign cnt_done = cnt_r == CW'(PRETRIGGER_DEPTH);
  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    gate_open_nxt = gate_open_r;
    fill_nxt      = fill_r;
    cnt_nxt       = cnt_r;
    smp_nxt       = smp_r;
    gate_nxt      = gate_r;
    frame_nxt     = frame_r;
    out_valid_nxt = out_valid_r && !out_ready;
    kind_nxt      = kind_r;
    osmp_nxt      = osmp_r;
    start_nxt     = start_r;
    oframe_nxt    = oframe_r;
    ocnt_nxt      = ocnt_r;
    last_nxt      = last_r;
    shift_en      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          smp_nxt   = SAMPLE_WIDTH'($unsigned(in_data_sample));
          gate_nxt  = in_trigger_sample > thr_r;
          frame_nxt = in_frame_time;
          state_nxt = ST_WORK;
        end
      end
      ST_WORK: begin
        if (gate_r && !gate_open_r) begin
          cnt_nxt   = '0;
          state_nxt = ST_DRAIN;
        end else if (!gate_r && !gate_open_r) begin
          shift_en  = 1'b1;
          fill_nxt  = (fill_r == CW'(PRETRIGGER_DEPTH)) ? fill_r : fill_r + 1'b1;
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          start_nxt     = 1'b0;
          ocnt_nxt      = '0;
          last_nxt      = 1'b1;
          if (gate_r) begin
            kind_nxt   = KIND_DATA;
            osmp_nxt   = OUT_SAMPLE_W'(smp_r);
            oframe_nxt = '0;
          end else begin
            kind_nxt      = KIND_END;
            osmp_nxt      = '0;
            oframe_nxt    = frame_r;
            shift_en      = 1'b1;
            fill_nxt      = (fill_r == CW'(PRETRIGGER_DEPTH)) ? fill_r : fill_r + 1'b1;
            gate_open_nxt = 1'b0;
          end
          state_nxt = ST_IDLE;
        end
      end
      ST_DRAIN: begin
        if (cnt_done) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            kind_nxt      = KIND_DATA;
            osmp_nxt      = OUT_SAMPLE_W'(smp_r);
            start_nxt     = (fill_r == '0);
            oframe_nxt    = (fill_r == '0) ? frame_r : '0;
            ocnt_nxt      = '0;
            last_nxt      = 1'b1;
            fill_nxt      = '0;
            gate_open_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end else if (skip) begin
          shift_en = 1'b1;
          cnt_nxt  = cnt_r + 1'b1;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = KIND_DATA;
          osmp_nxt      = OUT_SAMPLE_W'(head_q);
          start_nxt     = first;
          oframe_nxt    = first ? frame_r : '0;
          ocnt_nxt      = first ? COUNT_W'(fill_r) : '0;
          last_nxt      = 1'b0;
          shift_en      = 1'b1;
          cnt_nxt       = cnt_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      thr_r       <= '0;
      gate_open_r <= 1'b0;
      fill_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
      gate_open_r <= gate_open_nxt;
      fill_r      <= fill_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    smp_r    <= smp_nxt;
    gate_r   <= gate_nxt;
    frame_r  <= frame_nxt;
    kind_r   <= kind_nxt;
    osmp_r   <= osmp_nxt;
    start_r  <= start_nxt;
    oframe_r <= oframe_nxt;
    ocnt_r   <= ocnt_nxt;
    last_r   <= last_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_record_kind      = kind_r;
  assign out_sample_out       = osmp_r;
  assign out_entry_start      = start_r;
  assign out_event_frame      = oframe_r;
  assign out_pretrigger_count = ocnt_r;
  assign out_run_last         = last_r;

endmodule

// ===== hdl/pgc_cell.sv =====
// One cell of the pretrigger sample chain: a sample register that loads its input
// (the neighbor's value, or the new sample at the top) on every shift. No dependencies.
module pgc_cell #(
  parameter int unsigned W = 16
) (
  input  logic         clk,
  input  logic         shift_en,
  input  logic [W-1:0] d_in,
  output logic [W-1:0] q
);

  logic [W-1:0] q_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      q_r <= d_in;
    end
  end

  assign q = q_r;

endmodule
